### design/spmpc_pkg.sv
// Shared types, constants and SHA-256 helper functions for the Merkle proof checker.
package spmpc_pkg;

  localparam int HashW   = 256;
  localparam int VerdW   = 2;
  localparam int RoundN  = 64;
  localparam int CfgAddrW = 6;

  localparam logic [1:0] VERD_MATCH    = 2'd0;
  localparam logic [1:0] VERD_MISMATCH = 2'd1;
  localparam logic [1:0] VERD_NOROOT   = 2'd2;

  localparam logic KIND_LEAF    = 1'b0;
  localparam logic KIND_SIBLING = 1'b1;

  localparam logic [2:0] REG_ROOT0   = 3'd0;
  localparam logic [2:0] REG_ROOT1   = 3'd1;
  localparam logic [2:0] REG_ROOT2   = 3'd2;
  localparam logic [2:0] REG_ROOT3   = 3'd3;
  localparam logic [2:0] REG_PRESENT = 3'd4;

  localparam logic [255:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  // Padding block for a 64-byte message: 0x80, zeros, bit length 512.
  localparam logic [511:0] PAD_BLOCK = {8'h80, 488'd0, 16'h0200};

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD1, ST_RUN1, ST_LOAD2, ST_RUN2, ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_leaf;     // load the item hash as the running hash
    logic take_sibling;  // latch sibling and order the pair
    logic load_blk1;     // start compression of the data block
    logic load_blk2;     // start compression of the padding block
    logic round;         // run one round
    logic finish_blk1;   // add working vars into the chain state
    logic finish_blk2;   // add and write back the running hash
  } dp_cmd_t;

  typedef struct packed {
    logic last_round;
  } dp_sts_t;

  function automatic logic [31:0] sha_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k=32'h428a2f98; 6'd1: k=32'h71374491; 6'd2: k=32'hb5c0fbcf; 6'd3: k=32'he9b5dba5;
      6'd4: k=32'h3956c25b; 6'd5: k=32'h59f111f1; 6'd6: k=32'h923f82a4; 6'd7: k=32'hab1c5ed5;
      6'd8: k=32'hd807aa98; 6'd9: k=32'h12835b01; 6'd10: k=32'h243185be; 6'd11: k=32'h550c7dc3;
      6'd12: k=32'h72be5d74; 6'd13: k=32'h80deb1fe; 6'd14: k=32'h9bdc06a7; 6'd15: k=32'hc19bf174;
      6'd16: k=32'he49b69c1; 6'd17: k=32'hefbe4786; 6'd18: k=32'h0fc19dc6; 6'd19: k=32'h240ca1cc;
      6'd20: k=32'h2de92c6f; 6'd21: k=32'h4a7484aa; 6'd22: k=32'h5cb0a9dc; 6'd23: k=32'h76f988da;
      6'd24: k=32'h983e5152; 6'd25: k=32'ha831c66d; 6'd26: k=32'hb00327c8; 6'd27: k=32'hbf597fc7;
      6'd28: k=32'hc6e00bf3; 6'd29: k=32'hd5a79147; 6'd30: k=32'h06ca6351; 6'd31: k=32'h14292967;
      6'd32: k=32'h27b70a85; 6'd33: k=32'h2e1b2138; 6'd34: k=32'h4d2c6dfc; 6'd35: k=32'h53380d13;
      6'd36: k=32'h650a7354; 6'd37: k=32'h766a0abb; 6'd38: k=32'h81c2c92e; 6'd39: k=32'h92722c85;
      6'd40: k=32'ha2bfe8a1; 6'd41: k=32'ha81a664b; 6'd42: k=32'hc24b8b70; 6'd43: k=32'hc76c51a3;
      6'd44: k=32'hd192e819; 6'd45: k=32'hd6990624; 6'd46: k=32'hf40e3585; 6'd47: k=32'h106aa070;
      6'd48: k=32'h19a4c116; 6'd49: k=32'h1e376c08; 6'd50: k=32'h2748774c; 6'd51: k=32'h34b0bcb5;
      6'd52: k=32'h391c0cb3; 6'd53: k=32'h4ed8aa4a; 6'd54: k=32'h5b9cca4f; 6'd55: k=32'h682e6ff3;
      6'd56: k=32'h748f82ee; 6'd57: k=32'h78a5636f; 6'd58: k=32'h84c87814; 6'd59: k=32'h8cc70208;
      6'd60: k=32'h90befffa; 6'd61: k=32'ha4506ceb; 6'd62: k=32'hbef9a3f7; 6'd63: k=32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

### design/spmpc_ctrl.sv
// Controller state machine that sequences the two SHA-256 compressions.
module spmpc_ctrl
  import spmpc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  logic    in_kind,
  input  logic    in_final,
  output logic    out_tvalid,
  input  logic    out_tready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t state_r, state_nxt;
  logic   open_r, open_nxt;
  logic   fin_r, fin_nxt;
  logic   ovalid_r, ovalid_nxt;
  logic   acc;

  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = ovalid_r;

  // State and flag registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      open_r   <= 1'b0;
      fin_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      open_r   <= open_nxt;
      fin_r    <= fin_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt  = state_r;
    open_nxt   = open_r;
    fin_nxt    = fin_r;
    ovalid_nxt = ovalid_r && !out_tready;
    cmd        = '0;
    in_tready  = (state_r == ST_IDLE) && !ovalid_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_kind == KIND_LEAF) begin
            cmd.take_leaf = 1'b1;
            if (in_final) begin
              open_nxt   = 1'b0;
              ovalid_nxt = 1'b1;
            end else begin
              open_nxt = 1'b1;
            end
          end else if (open_r) begin
            cmd.take_sibling = 1'b1;
            fin_nxt          = in_final;
            state_nxt        = ST_LOAD1;
          end
        end
      end
      ST_LOAD1: begin
        cmd.load_blk1 = 1'b1;
        state_nxt     = ST_RUN1;
      end
      ST_RUN1: begin
        cmd.round = 1'b1;
        if (sts.last_round) state_nxt = ST_LOAD2;
      end
      ST_LOAD2: begin
        cmd.finish_blk1 = 1'b1;
        cmd.load_blk2   = 1'b1;
        state_nxt       = ST_RUN2;
      end
      ST_RUN2: begin
        cmd.round = 1'b1;
        if (sts.last_round) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.finish_blk2 = 1'b1;
        state_nxt       = ST_IDLE;
        if (fin_r) begin
          open_nxt   = 1'b0;
          ovalid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // A verdict is raised only from idle or at the end of a pair hash.
  a_verdict_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == ST_IDLE || $past(state_r) == ST_DONE))
    else $error("verdict raised from a busy state");
  // No item is taken while a verdict waits.
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> !in_tready)
    else $error("item taken while verdict pending");
  // The data-block compression always leads to the padding block.
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN1 && sts.last_round) |=> state_r == ST_LOAD2)
    else $error("padding block skipped");

endmodule

### design/spmpc_dp.sv
// Datapath: running hash, pair ordering, one-round-per-cycle SHA-256 core and root compare.
module spmpc_dp
  import spmpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  input  logic [HashW-1:0]  in_hash,
  input  logic [HashW-1:0]  root,
  input  logic              root_present,
  output logic [VerdW-1:0]  verdict
);

  logic [HashW-1:0] run_r, run_nxt;
  logic [511:0]     blk_r;      // message schedule window, w[t] in top word
  logic [255:0]     chain_r;    // chain state between blocks
  logic [31:0]      v_r [8];
  logic [5:0]       rnd_r;
  logic [HashW-1:0] cur;
  logic [31:0]      w0, w1, w9, w14, s0, s1, wn;
  logic [31:0]      e1, ch, t1, a0, mj, t2;
  logic [255:0]     vsum;

  assign sts.last_round = (rnd_r == 6'(RoundN - 1));

  // Schedule and round function.
  always_comb begin
    w0  = blk_r[511:480];
    w1  = blk_r[479:448];
    w9  = blk_r[223:192];
    w14 = blk_r[63:32];
    s0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    s1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    wn  = w0 + s0 + w9 + s1;
    e1  = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1  = v_r[7] + e1 + ch + sha_k(rnd_r) + w0;
    a0  = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    mj  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2  = a0 + mj;
    for (int i = 0; i < 8; i++) begin
      vsum[255-32*i -: 32] = chain_r[255-32*i -: 32] + v_r[i];
    end
  end

  assign cur = run_r;

  // Running hash register.
  always_comb begin
    run_nxt = run_r;
    if (cmd.take_leaf) run_nxt = in_hash;
    else if (cmd.finish_blk2) run_nxt = vsum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
      rnd_r <= '0;
    end else begin
      run_r <= run_nxt;
      if (cmd.load_blk1 || cmd.load_blk2) rnd_r <= '0;
      else if (cmd.round) rnd_r <= rnd_r + 6'd1;
    end
  end

  // Message block, chain and working variables.
  always_ff @(posedge clk) begin
    if (cmd.take_sibling) begin
      // Smaller hash first; a tie puts the sibling first.
      if (cur < in_hash) blk_r <= {cur, in_hash};
      else blk_r <= {in_hash, cur};
    end else if (cmd.load_blk2) begin
      blk_r <= PAD_BLOCK;
    end else if (cmd.round) begin
      blk_r <= {blk_r[479:0], wn};
    end
    if (cmd.load_blk1) chain_r <= SHA_IV;
    else if (cmd.finish_blk1) chain_r <= vsum;
    if (cmd.load_blk1 || cmd.load_blk2) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= cmd.load_blk1 ? SHA_IV[255-32*i -: 32] : vsum[255-32*i -: 32];
      end
    end else if (cmd.round) begin
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4]; v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0]; v_r[0] <= t1 + t2;
    end
  end

  // Verdict from the running hash and the root.
  always_comb begin
    if (!root_present) verdict = VERD_NOROOT;
    else if (run_r == root) verdict = VERD_MATCH;
    else verdict = VERD_MISMATCH;
  end

  // Rounds stop at the last one.
  a_rnd: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.round && sts.last_round) |=> !cmd.round)
    else $error("round counter overran");
  // The running hash changes only on a leaf or at the end of a pair.
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(cmd.take_leaf) && !$past(cmd.finish_blk2) && !$past(!rst_n) |-> $stable(run_r))
    else $error("running hash changed unexpectedly");
  // Leaf and sibling are never taken together.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.take_leaf && cmd.take_sibling))
    else $error("leaf and sibling taken together");

endmodule

### design/sorted_pair_merkle_proof_check_unit.sv
// Top level of the sorted-pair SHA-256 Merkle proof checker.
// A leaf item loads the running hash; its verdict, if final, is valid from the next cycle.
// A sibling item runs two 64-round compressions on one round unit plus
// take, load and finish steps; a final sibling's verdict goes valid as DONE ends.
// Synchronous active-low reset clears root, running hash and proof state.
// out_tvalid is registered and held until taken, and input waits meanwhile.
module sorted_pair_merkle_proof_check_unit
  import spmpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [255:0] in_tdata,  // hash_word0, hash_word1, hash_word2, hash_word3
  input  logic        in_tuser,   // kind
  input  logic        in_tlast,   // final_item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // verdict
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [63:0] root_r [4];
  logic        present_r;
  logic [HashW-1:0] hash_be;
  logic [VerdW-1:0] verdict;
  logic [2:0]  ridx;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_pready = 1'b1;
  assign ridx       = cfg_paddr[5:3];
  // Word 0 holds the first bytes, so it goes to the top of the hash vector.
  assign hash_be = {in_tdata[63:0], in_tdata[127:64], in_tdata[191:128], in_tdata[255:192]};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) root_r[i] <= '0;
      present_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (ridx)
        REG_ROOT0:   root_r[0] <= cfg_pwdata;
        REG_ROOT1:   root_r[1] <= cfg_pwdata;
        REG_ROOT2:   root_r[2] <= cfg_pwdata;
        REG_ROOT3:   root_r[3] <= cfg_pwdata;
        REG_PRESENT: present_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_ROOT0:   cfg_prdata = root_r[0];
      REG_ROOT1:   cfg_prdata = root_r[1];
      REG_ROOT2:   cfg_prdata = root_r[2];
      REG_ROOT3:   cfg_prdata = root_r[3];
      REG_PRESENT: cfg_prdata = {63'd0, present_r};
      default:     cfg_prdata = '0;
    endcase
  end

  spmpc_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .in_kind(in_tuser), .in_final(in_tlast),
    .out_tvalid, .out_tready, .cmd, .sts
  );

  spmpc_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .in_hash(hash_be),
    .root({root_r[0], root_r[1], root_r[2], root_r[3]}),
    .root_present(present_r), .verdict
  );

  assign out_tdata = {6'd0, verdict};

endmodule
